// ===== design/burh_pkg.sv =====
// Shared types and constants for the bounded undo/redo history.
`timescale 1ns / 1ps
`default_nettype none

package burh_pkg;

    // Fixed field widths
    localparam int CMD_BITS     = 3;
    localparam int PAYLOAD_BITS = 32;
    localparam int LABEL_BITS   = 16;
    localparam int CFG_BITS     = 7;
    localparam int COUNT_BITS   = 7;

    // Limit register value after reset
    localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = 7'd64;

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_UNDO   = 3'd1,
        CMD_REDO   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_STATUS = 3'd4
    } t_cmd;

    // One input transaction
    typedef struct packed {
        logic [CMD_BITS-1:0]     cmd;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [LABEL_BITS-1:0]   label_code;
        logic                    replace_top;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic                    ok;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic                    can_undo;
        logic                    can_redo;
        logic [LABEL_BITS-1:0]   undo_label;
        logic [LABEL_BITS-1:0]   redo_label;
        logic [COUNT_BITS-1:0]   entry_count;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;
        logic load;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== design/bounded_undo_redo_history.sv =====
// Top level of the bounded undo/redo history.
`timescale 1ns / 1ps
`default_nettype none

// Bounded undo/redo history kept in a ring of DEPTH entries. Each command
// transaction (push, undo, redo, clear, status) gives exactly one result
// transaction. The pointers and any push write are updated at the edge that
// accepts the command; the next cycle reads the restored payload and both
// peek labels from the entry memories (the label memory is read at two
// addresses), and the result is presented from registers in the cycle after.
// The next command is accepted in the same cycle that the pending result is
// taken, so a new command is not taken while the last one is still being
// read or its result waits; this is set by the registered memory read. The
// entry memories need no clearing pass, so the block takes commands straight
// out of reset. The max_entries write port is always ready and should be
// written only while no command is in flight.

module bounded_undo_redo_history #(
    parameter int DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire burh_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output burh_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [burh_pkg::CFG_BITS-1:0] i_cfg_data
);

    burh_pkg::t_dp_cmd w_dp_cmd;

    // Limit register accepts writes at any time
    assign o_cfg_ready = 1'b1;

    burh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (w_dp_cmd)
    );

    burh_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (w_dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== design/burh_ctrl.sv =====
// Controller state machine: sequences execute, read and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module burh_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output burh_pkg::t_dp_cmd       o_dp_cmd
);

    burh_pkg::t_state r_state;
    burh_pkg::t_state n_state;
    logic             w_accept;

    // Take a new transaction when idle or when the pending result leaves now
    always_comb begin
        case (r_state)
            burh_pkg::ST_IDLE: o_in_stall = 1'b0;
            burh_pkg::ST_OUT:  o_in_stall = i_out_stall;
            default:           o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            burh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = burh_pkg::ST_READ;
                end
            end
            burh_pkg::ST_READ: begin
                n_state = burh_pkg::ST_OUT;
            end
            burh_pkg::ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = w_accept ? burh_pkg::ST_READ : burh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = burh_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_dp_cmd.exec = w_accept;
        o_dp_cmd.load = 1'b0;
        o_out_valid   = 1'b0;
        case (r_state)
            burh_pkg::ST_READ: o_dp_cmd.load = 1'b1;
            burh_pkg::ST_OUT:  o_out_valid   = 1'b1;
            default: begin
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= burh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/burh_dp.sv =====
// Datapath: history pointers, entry memories and the result register.
`timescale 1ns / 1ps
`default_nettype none

module burh_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire burh_pkg::t_dp_cmd             i_dp_cmd,
    input  wire burh_pkg::t_in_item            i_in_data,
    input  wire logic                          i_cfg_write,
    input  wire logic [burh_pkg::CFG_BITS-1:0] i_cfg_data,
    output burh_pkg::t_out_item                o_out_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = IDX_W + 1;
    localparam int LW    = (SW > burh_pkg::CFG_BITS) ? SW : burh_pkg::CFG_BITS;

    // Ring slot of an offset from the oldest entry (offset at most DEPTH)
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [SW-1:0]    off);
        logic [SW-1:0] sum;
        sum = SW'(base) + off;
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Entry memories
    logic [burh_pkg::PAYLOAD_BITS-1:0] r_pay_mem [DEPTH];
    logic [burh_pkg::LABEL_BITS-1:0]   r_lab_mem [DEPTH];

    // History pointers and limit
    logic [burh_pkg::CFG_BITS-1:0] r_max_entries;
    logic [IDX_W-1:0]              r_oldest, n_oldest;
    logic [SW-1:0]                 r_held,   n_held;
    logic [IDX_W-1:0]              r_cursor, n_cursor;

    // Result flags and read data
    logic                              r_ok, n_ok;
    logic                              r_restore, n_restore;
    logic                              r_cu, r_cr;
    logic [SW-1:0]                     r_count;
    logic [burh_pkg::PAYLOAD_BITS-1:0] r_pay_rd;
    logic [burh_pkg::LABEL_BITS-1:0]   r_ulab_rd, r_rlab_rd;

    logic [LW-1:0]    w_max_ext;
    logic [SW-1:0]    w_lim;
    logic [SW-1:0]    w_cur_p1, w_cur_p2;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_cu, w_cr;
    logic [IDX_W-1:0] w_addr0, w_addr1;

    // Clamp the limit to 1..DEPTH
    assign w_max_ext = LW'(r_max_entries);
    always_comb begin
        if (w_max_ext == '0) begin
            w_lim = SW'(1);
        end else if (w_max_ext > LW'(DEPTH)) begin
            w_lim = SW'(DEPTH);
        end else begin
            w_lim = SW'(w_max_ext);
        end
    end

    assign w_cur_p1 = SW'(r_cursor) + SW'(1);
    assign w_cur_p2 = w_cur_p1 + SW'(1);

    // Work out the next pointers and the memory write for one transaction
    always_comb begin
        n_oldest  = r_oldest;
        n_held    = r_held;
        n_cursor  = r_cursor;
        n_ok      = 1'b1;
        n_restore = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_oldest;
        case (i_in_data.cmd)
            burh_pkg::CMD_PUSH: begin
                w_we = i_dp_cmd.exec;
                if (r_held == '0) begin
                    w_waddr  = r_oldest;
                    n_held   = SW'(1);
                    n_cursor = '0;
                end else if (i_in_data.replace_top && (w_cur_p1 == r_held)) begin
                    w_waddr = slot_of(r_oldest, SW'(r_cursor));
                end else begin
                    // Drop redo entries, append, then evict down to the limit
                    w_waddr = slot_of(r_oldest, w_cur_p1);
                    if (w_cur_p2 > w_lim) begin
                        n_oldest = slot_of(r_oldest, w_cur_p2 - w_lim);
                        n_held   = w_lim;
                        n_cursor = IDX_W'(w_lim - SW'(1));
                    end else begin
                        n_held   = w_cur_p2;
                        n_cursor = w_cur_p1[IDX_W-1:0];
                    end
                end
            end
            burh_pkg::CMD_UNDO: begin
                if ((r_held != '0) && (r_cursor != '0)) begin
                    n_cursor  = r_cursor - IDX_W'(1);
                    n_restore = 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            burh_pkg::CMD_REDO: begin
                if (w_cur_p1 < r_held) begin
                    n_cursor  = w_cur_p1[IDX_W-1:0];
                    n_restore = 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            burh_pkg::CMD_CLEAR: begin
                n_oldest = '0;
                n_held   = '0;
                n_cursor = '0;
            end
            burh_pkg::CMD_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    // Advance pointers and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= burh_pkg::MAX_ENTRIES_RESET;
            r_oldest      <= '0;
            r_held        <= '0;
            r_cursor      <= '0;
            r_ok          <= 1'b0;
            r_restore     <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_max_entries <= i_cfg_data;
            end
            if (i_dp_cmd.exec) begin
                r_oldest  <= n_oldest;
                r_held    <= n_held;
                r_cursor  <= n_cursor;
                r_ok      <= n_ok;
                r_restore <= n_restore;
            end
        end
    end

    // Peek flags and read addresses from the updated pointers
    assign w_cu    = (r_held != '0) && (r_cursor != '0);
    assign w_cr    = w_cur_p1 < r_held;
    assign w_addr0 = slot_of(r_oldest, SW'(r_cursor));
    assign w_addr1 = slot_of(r_oldest, w_cur_p1);

    // Write on push, read payload and both peek labels in the load cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_pay_mem[w_waddr] <= i_in_data.payload;
            r_lab_mem[w_waddr] <= i_in_data.label_code;
        end
        if (i_dp_cmd.load) begin
            r_pay_rd  <= r_pay_mem[w_addr0];
            r_ulab_rd <= r_lab_mem[w_addr0];
            r_rlab_rd <= r_lab_mem[w_addr1];
        end
    end

    // Capture status with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cu    <= 1'b0;
            r_cr    <= 1'b0;
            r_count <= '0;
        end else if (i_dp_cmd.load) begin
            r_cu    <= w_cu;
            r_cr    <= w_cr;
            r_count <= r_held;
        end
    end

    // Assemble the result, zeroing fields that do not apply
    always_comb begin
        o_out_data.ok          = r_ok;
        o_out_data.out_payload = r_restore ? r_pay_rd : '0;
        o_out_data.can_undo    = r_cu;
        o_out_data.can_redo    = r_cr;
        o_out_data.undo_label  = r_cu ? r_ulab_rd : '0;
        o_out_data.redo_label  = r_cr ? r_rlab_rd : '0;
        o_out_data.entry_count = burh_pkg::COUNT_BITS'(r_count);
    end

endmodule

`default_nettype wire
